/* rtl/core/assert_macros.svh */
// Assertion macros shared by the crop/resize/quantize core.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CRQ_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crq: implication check failed");

// Next-cycle implication, checked outside reset.
`define CRQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crq: next-cycle check failed");

// Condition that must hold in the cycle after a reset cycle.
`define CRQ_ASSERT_AFTER_RESET(label, cons) \
  label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("crq: post-reset check failed");

`endif

/* rtl/core/crq_pkg.sv */
// Shared types and constants for the crop/resize/quantize core.
// No dependencies; every module in rtl/core imports this package.
package crq_pkg;

  localparam int SZ_W       = 11;  // width of every size register
  localparam int GAIN_W     = 24;  // Q8.16 gain
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int ACC_W      = 22;  // holds up to 2047 * 2047
  localparam int INDEX_W    = 20;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_W,
    REG_SRC_H,
    REG_CROP_W,
    REG_CROP_H,
    REG_TGT_W,
    REG_TGT_H,
    REG_GAIN,
    REG_ZERO
  } cfg_reg_t;

  typedef struct packed {
    logic [SZ_W-1:0]   src_w;
    logic [SZ_W-1:0]   src_h;
    logic [SZ_W-1:0]   crop_w;
    logic [SZ_W-1:0]   crop_h;
    logic [SZ_W-1:0]   tgt_w;
    logic [SZ_W-1:0]   tgt_h;
    logic [GAIN_W-1:0] gain;
    logic signed [7:0] zero;
  } cfg_t;

  // One selected pixel on its way from the front to the back.
  typedef struct packed {
    logic [15:0]        pixel;
    logic [INDEX_W-1:0] index;
    logic               last;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

/* rtl/core/crq_front.sv */
// Front end: raster counters, centered-crop and nearest-neighbor selection.
// Depends on crq_pkg; writes selected pixels into crq_fifo.
module crq_front import crq_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_push,
  input  logic [15:0] in_pixel,
  input  logic        in_frame_start,
  output logic        in_full,
  input  fifo_stat_t  q_stat,
  output logic        q_wr,
  output item_t       q_wdata
);

  // Size registers are 11 bits, so a limit above 2047 never bites.
  localparam logic [SZ_W-1:0] W_MAX =
    (MAX_WIDTH > 2047) ? {SZ_W{1'b1}} : SZ_W'(MAX_WIDTH);
  localparam logic [SZ_W-1:0] H_MAX =
    (MAX_HEIGHT > 2047) ? {SZ_W{1'b1}} : SZ_W'(MAX_HEIGHT);

  function automatic logic [SZ_W-1:0] limit_size(input logic [SZ_W-1:0] v,
                                                 input logic [SZ_W-1:0] maxv);
    logic [SZ_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SZ_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

  logic [SZ_W-1:0]  sc_r, sr_r, tc_r, tr_r;
  logic [SZ_W-1:0]  sc_nxt, sr_nxt, tc_nxt, tr_nxt;
  logic [ACC_W-1:0] csa_r, cta_r, rsa_r, rta_r;
  logic [ACC_W-1:0] csa_nxt, cta_nxt, rsa_nxt, rta_nxt;

  logic [SZ_W-1:0]  sc, sr, tc, tr;
  logic [ACC_W-1:0] csa, cta, rsa, rta;

  logic [SZ_W-1:0] w, h, cw0, ch0, cw, ch, tw, th, x0, y0, x_end, y_end;
  logic            col_in, row_in, col_sel, row_sel, sel, accept;
  logic [SZ_W:0]   sc_inc;
  logic [2*SZ_W-1:0] idx_full;

  // Effective geometry after clamping.
  always_comb begin
    w     = limit_size(cfg.src_w, W_MAX);
    h     = limit_size(cfg.src_h, H_MAX);
    cw0   = limit_size(cfg.crop_w, W_MAX);
    ch0   = limit_size(cfg.crop_h, H_MAX);
    cw    = (cw0 > w) ? w : cw0;
    ch    = (ch0 > h) ? h : ch0;
    tw    = limit_size(cfg.tgt_w, W_MAX);
    th    = limit_size(cfg.tgt_h, H_MAX);
    tw    = (tw > cw) ? cw : tw;
    th    = (th > ch) ? ch : th;
    x0    = (w - cw) >> 1;
    y0    = (h - ch) >> 1;
    x_end = x0 + cw;
    y_end = y0 + ch;
  end

  // A frame start clears the counters before this pixel is placed.
  always_comb begin
    sc  = in_frame_start ? '0 : sc_r;
    sr  = in_frame_start ? '0 : sr_r;
    tc  = in_frame_start ? '0 : tc_r;
    tr  = in_frame_start ? '0 : tr_r;
    csa = in_frame_start ? '0 : csa_r;
    cta = in_frame_start ? '0 : cta_r;
    rsa = in_frame_start ? '0 : rsa_r;
    rta = in_frame_start ? '0 : rta_r;
  end

  always_comb begin
    col_in  = (sc >= x0) && (sc < x_end);
    row_in  = (sr >= y0) && (sr < y_end);
    col_sel = col_in && (tc < tw) &&
              ({1'b0, cta} < ({1'b0, csa} + (ACC_W+1)'(tw)));
    row_sel = row_in && (tr < th) &&
              ({1'b0, rta} < ({1'b0, rsa} + (ACC_W+1)'(th)));
    sel     = col_sel && row_sel;
    accept  = in_push && !q_stat.full;
  end

  assign in_full = q_stat.full;
  assign q_wr    = accept && sel;

  always_comb begin
    idx_full        = ((2*SZ_W)'(tr) * (2*SZ_W)'(tw)) + (2*SZ_W)'(tc);
    q_wdata.pixel   = in_pixel;
    q_wdata.index   = idx_full[INDEX_W-1:0];
    q_wdata.last    = (tr == th - SZ_W'(1)) && (tc == tw - SZ_W'(1));
  end

  always_comb begin
    tc_nxt  = tc;
    cta_nxt = cta;
    csa_nxt = csa;
    tr_nxt  = tr;
    rta_nxt = rta;
    rsa_nxt = rsa;
    sr_nxt  = sr;
    if (col_in) begin
      if (col_sel) begin
        tc_nxt  = tc + SZ_W'(1);
        cta_nxt = cta + ACC_W'(cw);
      end
      csa_nxt = csa + ACC_W'(tw);
    end
    sc_inc = {1'b0, sc} + (SZ_W+1)'(1);
    if (sc_inc >= {1'b0, w}) begin
      sc_nxt  = '0;
      tc_nxt  = '0;
      csa_nxt = '0;
      cta_nxt = '0;
      if (row_in) begin
        if (row_sel) begin
          tr_nxt  = tr + SZ_W'(1);
          rta_nxt = rta + ACC_W'(ch);
        end
        rsa_nxt = rsa + ACC_W'(th);
      end
      if (sr < h) begin
        sr_nxt = sr + SZ_W'(1);
      end
    end else begin
      sc_nxt = sc_inc[SZ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r  <= '0;
      sr_r  <= '0;
      tc_r  <= '0;
      tr_r  <= '0;
      csa_r <= '0;
      cta_r <= '0;
      rsa_r <= '0;
      rta_r <= '0;
    end else if (accept) begin
      sc_r  <= sc_nxt;
      sr_r  <= sr_nxt;
      tc_r  <= tc_nxt;
      tr_r  <= tr_nxt;
      csa_r <= csa_nxt;
      cta_r <= cta_nxt;
      rsa_r <= rsa_nxt;
      rta_r <= rta_nxt;
    end
  end

endmodule

/* rtl/core/crq_fifo.sv */
// Short queue of selected pixels between the front and the back.
// Depends on crq_pkg for item_t, fifo_stat_t and the depth constants.
module crq_fifo import crq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr,
  input  item_t      wdata,
  input  logic       rd,
  output item_t      rdata,
  output fifo_stat_t stat
);

  item_t                 mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wp_r, rp_r;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;

  assign rdata      = mem_r[rp_r];
  assign stat.full  = (cnt_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr && !rd) begin
      cnt_nxt = cnt_r + FIFO_CNT_W'(1);
    end else if (rd && !wr) begin
      cnt_nxt = cnt_r - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) begin
        wp_r <= wp_r + FIFO_PTR_W'(1);
      end
      if (rd) begin
        rp_r <= rp_r + FIFO_PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* rtl/core/crq_back.sv */
// Back end: channel expansion, Q8.16 gain, zero point and int8 saturation.
// Depends on crq_pkg; drains crq_fifo into the result register.
module crq_back import crq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  fifo_stat_t        q_stat,
  input  item_t             q_rdata,
  output logic              q_rd,
  output logic              out_empty,
  input  logic              out_pop,
  output logic signed [7:0] out_red_q,
  output logic signed [7:0] out_green_q,
  output logic signed [7:0] out_blue_q,
  output logic [INDEX_W-1:0] out_pixel_index,
  output logic              out_last
);

  // Truncating expansion c*255/31: 255/31 is 8 plus 7/31, and the fraction
  // floor(7*c/31) counts how many of its steps c has passed.
  function automatic logic [7:0] expand5(input logic [4:0] c);
    logic [2:0] frac;
    frac = 3'(c >= 5'd5)  + 3'(c >= 5'd9)  + 3'(c >= 5'd14) + 3'(c >= 5'd18) +
           3'(c >= 5'd23) + 3'(c >= 5'd27) + 3'(c >= 5'd31);
    return {c, 3'b000} + 8'(frac);
  endfunction

  // Truncating expansion c*255/63: 255/63 is 4 plus 1/21.
  function automatic logic [7:0] expand6(input logic [5:0] c);
    logic [1:0] frac;
    frac = 2'(c >= 6'd21) + 2'(c >= 6'd42) + 2'(c >= 6'd63);
    return {c, 2'b00} + 8'(frac);
  endfunction

  localparam logic signed [17:0] Q_MAX = 18'sd127;
  localparam logic signed [17:0] Q_MIN = -18'sd128;

  function automatic logic [7:0] quantize(input logic [7:0]        v,
                                          input logic [GAIN_W-1:0] gain,
                                          input logic signed [7:0] zero);
    logic [31:0]        prod;
    logic signed [17:0] q;
    logic [7:0]         r;
    prod = (32'(v) * 32'(gain)) + 32'd32768;
    q    = $signed({2'b00, prod[31:16]}) + {{10{zero[7]}}, zero};
    if (q > Q_MAX) begin
      r = Q_MAX[7:0];
    end else if (q < Q_MIN) begin
      r = Q_MIN[7:0];
    end else begin
      r = q[7:0];
    end
    return r;
  endfunction

  logic              valid_r;
  logic signed [7:0] red_r, green_r, blue_r;
  logic [INDEX_W-1:0] index_r;
  logic              last_r;
  logic [7:0]        r8, g8, b8;

  assign q_rd = !q_stat.empty && (!valid_r || out_pop);

  always_comb begin
    r8 = expand5(q_rdata.pixel[15:11]);
    g8 = expand6(q_rdata.pixel[10:5]);
    b8 = expand5(q_rdata.pixel[4:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_rd) begin
      valid_r <= 1'b1;
    end else if (out_pop) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      red_r   <= quantize(r8, cfg.gain, cfg.zero);
      green_r <= quantize(g8, cfg.gain, cfg.zero);
      blue_r  <= quantize(b8, cfg.gain, cfg.zero);
      index_r <= q_rdata.index;
      last_r  <= q_rdata.last;
    end
  end

  assign out_empty       = !valid_r;
  assign out_red_q       = red_r;
  assign out_green_q     = green_r;
  assign out_blue_q      = blue_r;
  assign out_pixel_index = index_r;
  assign out_last        = last_r;

endmodule

/* rtl/core/crop_resize_quantize_rgb565_core.sv */
// Top level of the RGB565 crop, nearest-neighbor downscale and int8 quantizer.
// Depends on crq_pkg, assert_macros.svh, crq_front, crq_fifo and crq_back.
//
//   Channel   Direction  Handshake              Payload
//   in_       input      in_push / in_full      in_pixel, in_frame_start
//   out_      output     out_pop / out_empty    out_red_q, out_green_q, out_blue_q,
//                                               out_pixel_index, out_last
//   cfg_      input      cfg_we                 cfg_index, cfg_wdata
//
// One pixel transaction is taken every cycle while in_full is low; the front
// end decides selection in the accepting cycle, so pixels need no gap. A
// selected pixel is written into the four-entry queue at the accepting edge and
// moves into the quantizer register at the next edge when that register is
// free, and from there it drives the result ports. in_full is high while the
// queue holds four entries, that is with five results unread, and then every
// pixel waits, selected or not. Reset is synchronous and active low; it clears
// the counters, the queue and the result register and reloads the default
// register values.
`include "assert_macros.svh"

module crop_resize_quantize_rgb565_core import crq_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input pixel channel.
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [15:0]           in_pixel,
  input  logic                  in_frame_start,
  // Result channel.
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic signed [7:0]     out_red_q,
  output logic signed [7:0]     out_green_q,
  output logic signed [7:0]     out_blue_q,
  output logic [INDEX_W-1:0]    out_pixel_index,
  output logic                  out_last,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers. Writes land immediately and are picked up by
  // the next transaction; software must only write while the core is idle (not enforced here).
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_w  <= SZ_W'(320);
      cfg_r.src_h  <= SZ_W'(240);
      cfg_r.crop_w <= SZ_W'(240);
      cfg_r.crop_h <= SZ_W'(240);
      cfg_r.tgt_w  <= SZ_W'(96);
      cfg_r.tgt_h  <= SZ_W'(96);
      cfg_r.gain   <= GAIN_W'(65536);
      cfg_r.zero   <= -8'sd128;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SRC_W:  cfg_r.src_w  <= cfg_wdata[SZ_W-1:0];
        REG_SRC_H:  cfg_r.src_h  <= cfg_wdata[SZ_W-1:0];
        REG_CROP_W: cfg_r.crop_w <= cfg_wdata[SZ_W-1:0];
        REG_CROP_H: cfg_r.crop_h <= cfg_wdata[SZ_W-1:0];
        REG_TGT_W:  cfg_r.tgt_w  <= cfg_wdata[SZ_W-1:0];
        REG_TGT_H:  cfg_r.tgt_h  <= cfg_wdata[SZ_W-1:0];
        REG_GAIN:   cfg_r.gain   <= cfg_wdata[GAIN_W-1:0];
        REG_ZERO:   cfg_r.zero   <= $signed(cfg_wdata[7:0]);
        default:    cfg_r        <= cfg_r;
      endcase
    end
  end

  fifo_stat_t q_stat;
  logic       q_wr, q_rd;
  item_t      q_wdata, q_rdata;

  // Front end: places every pixel in the frame and forwards the selected ones.
  crq_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_push        (in_push),
    .in_pixel       (in_pixel),
    .in_frame_start (in_frame_start),
    .in_full        (in_full),
    .q_stat         (q_stat),
    .q_wr           (q_wr),
    .q_wdata        (q_wdata)
  );

  // Queue that lets the front keep accepting while a result waits.
  crq_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .wdata (q_wdata),
    .rd    (q_rd),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // Back end: quantizes one queued pixel per cycle into the result register while that register is free or popped.
  crq_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_stat          (q_stat),
    .q_rdata         (q_rdata),
    .q_rd            (q_rd),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_red_q       (out_red_q),
    .out_green_q     (out_green_q),
    .out_blue_q      (out_blue_q),
    .out_pixel_index (out_pixel_index),
    .out_last        (out_last)
  );

  // The result register is empty right after reset.
  `CRQ_ASSERT_AFTER_RESET(a_empty_after_reset, out_empty)
  // The front never writes into a full queue.
  `CRQ_ASSERT_IMPLIES(a_no_overflow, q_wr, !q_stat.full)
  // The back never reads an empty queue.
  `CRQ_ASSERT_IMPLIES(a_no_underflow, q_rd, !q_stat.empty)
  // Results only come out of the queue: nothing queued, nothing shown.
  `CRQ_ASSERT_NEXT(a_no_phantom, q_stat.empty && out_empty, out_empty)

endmodule
